### hw/rtl/ecgr_pkg.sv
// Shared types, constants and font ROM for the error code glyph renderer.
// No dependencies; imported by every module of the block except ecgr_fifo.
`timescale 1ns / 1ps
`default_nettype none

package ecgr_pkg;

	// Code clamp and divide-by-ten reciprocal (exact for codes below 180)
	localparam int CODE_W      = 8;
	localparam int CODE_MAX    = 99;
	localparam int DIV10_MUL   = 205;
	localparam int DIV10_SHIFT = 11;

	// Glyph placement on the panel, rows counted from the top
	localparam int GLYPH_W    = 5;
	localparam int GLYPH_H    = 7;
	localparam int TOP_ROW    = 2;
	localparam int LOWER_ROW  = 11;
	localparam int FIRST_COL  = 4;
	localparam int SECOND_COL = 11;

	// Output packing: 8 bytes of two 4-bit pixels per word
	localparam int LEVEL_W       = 4;
	localparam int WORD_W        = 64;
	localparam int PIX_PER_WORD  = 16;
	localparam int WIDX_W        = 5;
	localparam int COORD_W       = 6;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'hF;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef logic [GLYPH_W-1:0] glyph_row_t;

	// One classified item: the two digits to draw
	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] ones;
	} digits_t;

	localparam glyph_row_t DIGIT_ROM [10][GLYPH_H] = '{
		'{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
		'{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
		'{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
		'{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
		'{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
		'{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
		'{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
		'{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
		'{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
		'{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}
	};
	localparam glyph_row_t LETTER_C_ROM [GLYPH_H] =
		'{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
	localparam glyph_row_t LETTER_E_ROM [GLYPH_H] =
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};

	// Font row lookups; out-of-range selects read as blank
	function automatic glyph_row_t digit_row(input logic [3:0] d, input logic [2:0] r);
		glyph_row_t row;
		row = '0;
		if (d <= 4'd9 && r < 3'(GLYPH_H)) begin
			row = DIGIT_ROM[d][r];
		end
		return row;
	endfunction

	function automatic glyph_row_t c_row(input logic [2:0] r);
		glyph_row_t row;
		row = '0;
		if (r < 3'(GLYPH_H)) begin
			row = LETTER_C_ROM[r];
		end
		return row;
	endfunction

	function automatic glyph_row_t e_row(input logic [2:0] r);
		glyph_row_t row;
		row = '0;
		if (r < 3'(GLYPH_H)) begin
			row = LETTER_E_ROM[r];
		end
		return row;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/error_code_glyph_renderer.sv
// Error code glyph renderer: draws "CE" over a two-digit code as packed pixels.
// Throughput: one 64-bit word per cycle while out_ready does not stall the output;
// 25 words per code at PANEL_SIZE 20 (ceil(ceil(PANEL_SIZE^2/2)/8) in general), set
// by the word sequencer, which takes the next queued code as the last word advances.
// Reset: on_level returns to 15, queue empties, no output is pending.
// Depends on ecgr_pkg, ecgr_front, ecgr_fifo and ecgr_back.
`timescale 1ns / 1ps
`default_nettype none

module error_code_glyph_renderer #(
	parameter int PANEL_SIZE = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ecgr_pkg::LEVEL_W-1:0]  cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ecgr_pkg::CODE_W-1:0]   error_code,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ecgr_pkg::WORD_W-1:0]        pixel_word,
	output logic [ecgr_pkg::WIDX_W-1:0]        word_index,
	output logic                               last
);
	import ecgr_pkg::*;

	logic [LEVEL_W-1:0] on_level_q;
	logic               q_full;
	logic               q_push;
	digits_t            q_wdata;
	logic               q_pop;
	logic               q_valid;
	digits_t            q_rdata;

	// Intensity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_level_q <= LEVEL_RESET;
		end else if (cfg_we) begin
			on_level_q <= cfg_wdata;
		end
	end

	ecgr_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.error_code (error_code),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	ecgr_fifo #(
		.WIDTH ($bits(digits_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.not_empty (q_valid)
	);

	ecgr_back #(
		.PANEL_SIZE (PANEL_SIZE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.on_level   (on_level_q),
		.q_valid    (q_valid),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_word (pixel_word),
		.word_index (word_index),
		.last       (last)
	);

endmodule

`default_nettype wire

### hw/rtl/ecgr_fifo.sv
// Small register-based queue between the front and back parts.
// Uses no package; width and depth come from parameters.
`timescale 1ns / 1ps
`default_nettype none

module ecgr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ecgr_front.sv
// Front part: accepts error codes, clamps them and splits the two digits.
// Depends on ecgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecgr_front (
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [ecgr_pkg::CODE_W-1:0] error_code,
	input  wire logic                        q_full,
	output logic                             q_push,
	output ecgr_pkg::digits_t                q_data
);
	import ecgr_pkg::*;

	localparam int PROD_W = 15;

	logic [6:0]        code_c;
	logic [PROD_W-1:0] prod;
	logic [3:0]        tens;
	logic [6:0]        tens_x10;

	// Saturate to 99
	assign code_c = (error_code > CODE_W'(CODE_MAX)) ? 7'(CODE_MAX) : error_code[6:0];

	// Divide by ten through a reciprocal multiply
	assign prod     = PROD_W'(code_c) * PROD_W'(DIV10_MUL);
	assign tens     = prod[DIV10_SHIFT +: 4];
	assign tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});

	assign q_data.tens = tens;
	assign q_data.ones = 4'(code_c - tens_x10);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

### hw/rtl/ecgr_back.sv
// Back part: renders the image one 16-pixel word per cycle when not
// stalled, from the font ROM to registered output. Depends on ecgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecgr_back #(
	parameter int PANEL_SIZE = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [ecgr_pkg::LEVEL_W-1:0]  on_level,
	input  wire logic                          q_valid,
	input  wire ecgr_pkg::digits_t             q_data,
	output logic                               q_pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ecgr_pkg::WORD_W-1:0]        pixel_word,
	output logic [ecgr_pkg::WIDX_W-1:0]        word_index,
	output logic                               last
);
	import ecgr_pkg::*;

	localparam int PIX_COUNT  = PANEL_SIZE * PANEL_SIZE;
	localparam int BYTE_COUNT = (PIX_COUNT + 1) / 2;
	localparam int WORD_COUNT = (BYTE_COUNT + 7) / 8;
	localparam int KW         = $clog2(WORD_COUNT);
	localparam int CW         = $clog2(PANEL_SIZE);
	localparam int RW         = $clog2(PANEL_SIZE + 1);

	logic            busy_q;
	logic [KW-1:0]   k_q;
	logic [CW-1:0]   col0_q;
	logic [RW-1:0]   row0_q;
	digits_t         dig_q;
	logic            out_valid_q;
	logic [WORD_W-1:0] pixel_word_q;
	logic [WIDX_W-1:0] word_index_q;
	logic            last_q;

	logic            adv;
	logic            is_last;
	logic [CW:0]     col_next;
	logic [WORD_W-1:0] word_c;

	// One word per cycle while the output slot is free
	assign adv     = busy_q && (!out_valid_q || out_ready);
	assign is_last = (k_q == KW'(WORD_COUNT - 1));
	assign q_pop   = q_valid && (!busy_q || (adv && is_last));

	// Next word start: 16 pixels on, wrapping at most once per word
	assign col_next = {1'b0, col0_q} + (CW + 1)'(PIX_PER_WORD);

	// Pixel lanes
	for (genvar i = 0; i < PIX_PER_WORD; i++) begin : g_lane
		localparam int NIB_LO = (i % 2 == 0) ? 4 * i + 4 : 4 * i - 4;

		logic [CW:0]        csum;
		logic               wrap;
		logic [CW-1:0]      col;
		logic [RW-1:0]      rb;
		logic               on_panel;
		logic [COORD_W-1:0] rt6;
		logic [COORD_W-1:0] c6;
		logic               top_h;
		logic               bot_h;
		logic               left_h;
		logic               right_h;
		logic [2:0]         gr;
		logic [2:0]         gc;
		glyph_row_t         bits;
		logic               lit;

		assign csum = {1'b0, col0_q} + (CW + 1)'(i);
		assign wrap = (csum >= (CW + 1)'(PANEL_SIZE));
		assign col  = wrap ? CW'(csum - (CW + 1)'(PANEL_SIZE)) : csum[CW-1:0];
		assign rb   = row0_q + RW'(wrap);
		assign on_panel = (rb < RW'(PANEL_SIZE));

		// Row from the top and column on common coordinate width
		assign rt6 = COORD_W'(PANEL_SIZE - 1) - COORD_W'(rb);
		assign c6  = COORD_W'(col);

		assign top_h   = (rt6 >= COORD_W'(TOP_ROW)) &&
			(rt6 < COORD_W'(TOP_ROW + GLYPH_H));
		assign bot_h   = (rt6 >= COORD_W'(LOWER_ROW)) &&
			(rt6 < COORD_W'(LOWER_ROW + GLYPH_H));
		assign left_h  = (c6 >= COORD_W'(FIRST_COL)) &&
			(c6 < COORD_W'(FIRST_COL + GLYPH_W));
		assign right_h = (c6 >= COORD_W'(SECOND_COL)) &&
			(c6 < COORD_W'(SECOND_COL + GLYPH_W));

		assign gr = top_h ? 3'(rt6 - COORD_W'(TOP_ROW)) : 3'(rt6 - COORD_W'(LOWER_ROW));
		assign gc = left_h ? 3'(c6 - COORD_W'(FIRST_COL)) : 3'(c6 - COORD_W'(SECOND_COL));

		// Font row for whichever glyph covers this pixel
		always_comb begin
			bits = '0;
			if (top_h && left_h) begin
				bits = c_row(gr);
			end else if (top_h && right_h) begin
				bits = e_row(gr);
			end else if (bot_h && left_h) begin
				bits = digit_row(dig_q.tens, gr);
			end else if (bot_h && right_h) begin
				bits = digit_row(dig_q.ones, gr);
			end
		end

		// Bit 4 is the leftmost glyph column
		assign lit = on_panel && (gc < 3'(GLYPH_W)) && bits[3'(GLYPH_W - 1) - gc];
		assign word_c[NIB_LO +: LEVEL_W] = lit ? on_level : '0;
	end

	// Sequencer: current item, word count and start pixel of the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			col0_q <= '0;
			row0_q <= '0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				col0_q <= '0;
				row0_q <= '0;
			end else if (adv) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end
				k_q <= k_q + 1'b1;
				if (col_next >= (CW + 1)'(PANEL_SIZE)) begin
					col0_q <= CW'(col_next - (CW + 1)'(PANEL_SIZE));
					row0_q <= row0_q + 1'b1;
				end else begin
					col0_q <= col_next[CW-1:0];
				end
			end
		end
	end

	// Digits of the item being drawn
	always_ff @(posedge clk) begin
		if (q_pop) begin
			dig_q <= q_data;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_word_q <= word_c;
			word_index_q <= WIDX_W'(k_q);
			last_q       <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_word = pixel_word_q;
	assign word_index = word_index_q;
	assign last       = last_q;

endmodule

`default_nettype wire
